// ----- rtl/lca_pkg.sv -----
// ----------------------------------------------------------------------------
// lca_pkg
// Shared sizes, request codes and register indexes for the life automaton.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ADDR_W  = $clog2(MAX_ROWS);      // row word address
  localparam int COL_AW  = $clog2(MAX_COLS);      // bit position in a row word
  localparam int CNT_W   = $clog2(MAX_ROWS + 1);  // sweep counter, holds MAX_ROWS
  localparam int CFG_W   = 7;                     // size register width
  localparam int DIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int GEN_W   = 16;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

endpackage

// ----- rtl/lca_ram.sv -----
// ----------------------------------------------------------------------------
// lca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lca_life.sv -----
// ----------------------------------------------------------------------------
// lca_life
// Next generation of one row word by B3/S23 from its two neighbor rows.
// Columns outside the mask keep their stored value.
// ----------------------------------------------------------------------------
module lca_life
  import lca_pkg::*;
(
  input  row_t above,     // masked, zero when outside the board
  input  row_t mid,       // masked
  input  row_t below,     // masked, zero when outside the board
  input  row_t mid_raw,   // stored row, unmasked
  input  row_t col_mask,
  output row_t next_row
);

  row_t a_l, a_r, m_l, m_r, b_l, b_r;
  row_t life;

  // bit c of *_l holds column c-1, bit c of *_r holds column c+1
  assign a_l = above << 1;
  assign a_r = above >> 1;
  assign m_l = mid << 1;
  assign m_r = mid >> 1;
  assign b_l = below << 1;
  assign b_r = below >> 1;

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < MAX_COLS; c++) begin
      n = 4'(a_l[c]) + 4'(above[c]) + 4'(a_r[c]) + 4'(m_l[c]) + 4'(m_r[c])
        + 4'(b_l[c]) + 4'(below[c]) + 4'(b_r[c]);
      life[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
    end
  end

  assign next_row = (life & col_mask) | (mid_raw & ~col_mask);

endmodule

// ----- rtl/life_cellular_automaton_step.sv -----
// ----------------------------------------------------------------------------
// life_cellular_automaton_step
// Game of Life board (B3/S23) with cell write, cell read and one-generation
// advance requests; board held as row words in a single RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_stall | req_type row_index col_index
//          |           |                     | cell_in
//  out     | source    | out_valid/out_stall | cell_out generation_count status
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index cfg_data
//
//  A read/write beat steps through RAM read, modify/write and result.
//  Advance sweeps min(rows_in_use, 64) rows: the RAM read port delivers
//  one row word per cycle and the new row is written back two rows behind.
//  Out-of-range and no-op beats go straight to the result step.
//  Reset clears all row valid bits (board reads as dead), the generation
//  count and the sizes (64 x 64); no clearing pass is needed.
//  One beat in flight at a time; in_stall is high until its result sits in
//  the output register, which holds while out_stall is high.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step
  import lca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [5:0]        row_index,
  input  logic [5:0]        col_index,
  input  logic              cell_in,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              cell_out,
  output logic [GEN_W-1:0]  generation_count,
  output logic              status,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_ADV,
    S_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  rows_in_use, cols_in_use;
  logic [DIM_W-1:0]  nr, nc;          // effective sizes, capped at the array size
  row_t              col_mask;

  // latched request
  req_t              req;
  logic [ADDR_W-1:0] req_row;
  logic [COL_AW-1:0] req_col;
  logic              req_cell;

  // advance sweep
  logic [DIM_W-1:0]  cnt;             // next row to read
  logic              stg_on;          // read data stage active
  logic [DIM_W-1:0]  stg_row;         // row whose word arrives this cycle
  logic              stg_rd;          // that row was really read
  row_t              win_a;           // masked row stg_row-2
  row_t              win_b;           // masked row stg_row-1
  row_t              win_b_raw;       // stored row stg_row-1

  logic [GEN_W-1:0]  gen_cnt;
  logic              res_cell, res_status;

  // RAM and valid bits
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  row_t              ram_wdata, ram_rdata;
  logic [MAX_ROWS-1:0] row_vld;
  logic              rd_vld;
  row_t              rd_word;         // stored word, dead when never written
  row_t              rd_masked;
  row_t              new_row;
  row_t              wr_word;

  logic              in_acc;
  logic              in_range;
  logic              out_free;
  logic              issue;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(64);
      cols_in_use <= CFG_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS: rows_in_use <= cfg_data;
        CFG_COLS: cols_in_use <= cfg_data;
      endcase
    end
  end

  assign nr = (DIM_W'(rows_in_use) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                      : DIM_W'(rows_in_use);
  assign nc = (DIM_W'(cols_in_use) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                      : DIM_W'(cols_in_use);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = DIM_W'(c) < nc;
    end
  end

  // ---- request side ----
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (DIM_W'(row_index) < nr) && (DIM_W'(col_index) < nc);
  assign out_free = !out_valid || !out_stall;
  assign issue    = (state == S_ADV) && (cnt <= nr);

  // ---- row storage ----
  lca_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address: the request row on accept, otherwise the sweep row
  assign ram_raddr = (state == S_IDLE) ? ADDR_W'(row_index) : ADDR_W'(cnt);

  assign rd_word   = rd_vld ? ram_rdata : '0;
  assign rd_masked = (stg_rd ? rd_word : '0) & col_mask;

  lca_life u_life (
    .above    (win_a),
    .mid      (win_b),
    .below    (rd_masked),
    .mid_raw  (win_b_raw),
    .col_mask (col_mask),
    .next_row (new_row)
  );

  always_comb begin
    wr_word          = rd_word;
    wr_word[req_col] = req_cell;
  end

  // single write port: cell update or write-back two rows behind the sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_row;
    ram_wdata = wr_word;
    if (state == S_RMW && req == REQ_WRITE) begin
      ram_we = 1'b1;
    end else if (state == S_ADV && stg_on && stg_row != '0) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(stg_row - DIM_W'(1));
      ram_wdata = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (ram_we) begin
      row_vld[ram_waddr] <= 1'b1;
    end
    rd_vld <= row_vld[ram_raddr];
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gen_cnt   <= '0;
      out_valid <= 1'b0;
      stg_on    <= 1'b0;
    end else begin
      // drain the output register unless a new result is loaded this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            req        <= req_t'(req_type);
            req_row    <= ADDR_W'(row_index);
            req_col    <= COL_AW'(col_index);
            req_cell   <= cell_in;
            res_cell   <= 1'b0;
            res_status <= 1'b0;
            cnt        <= '0;
            stg_on     <= 1'b0;
            win_a      <= '0;
            win_b      <= '0;
            win_b_raw  <= '0;
            unique case (req_t'(req_type))
              REQ_WRITE, REQ_READ: begin
                if (in_range) begin
                  state <= S_RMW;
                end else begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end
              end
              REQ_ADVANCE: state <= S_ADV;
              REQ_NOP:     state <= S_DONE;
            endcase
          end
        end
        S_RMW: begin
          if (req == REQ_READ) begin
            res_cell <= rd_word[req_col];
          end
          state <= S_DONE;
        end
        S_ADV: begin
          // issue is already low once the last row reaches the stage
          stg_on  <= issue;
          stg_row <= cnt;
          stg_rd  <= cnt < nr;
          if (issue) begin
            cnt <= cnt + DIM_W'(1);
          end
          if (stg_on) begin
            win_a     <= win_b;
            win_b     <= rd_masked;
            win_b_raw <= rd_word;
            if (stg_row == nr) begin
              if (gen_cnt != GEN_MAX) begin
                gen_cnt <= gen_cnt + GEN_W'(1);
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            cell_out         <= res_cell;
            status           <= res_status;
            generation_count <= gen_cnt;
            state            <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // sweep write-back never lands outside the rows in use
  a_wb_in_board: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV && ram_we) |-> (DIM_W'(ram_waddr) < nr))
    else $error("advance write-back outside rows in use");

  // a result is loaded only from the done state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == S_DONE))
    else $error("result loaded outside done state");

  // generation counter moves by one, only at the end of an advance
  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && gen_cnt != $past(gen_cnt)) |->
      (gen_cnt == $past(gen_cnt) + GEN_W'(1) && state == S_DONE))
    else $error("generation count changed unexpectedly");
`endif

endmodule
